// ----- rtl/core/iso_on_tcp_connect_responder_assert.svh -----
// Assertion macros for the ISO-on-TCP connection responder.
// Included by the top level; no other dependencies.
`ifndef ISO_ON_TCP_CONNECT_RESPONDER_ASSERT_SVH
`define ISO_ON_TCP_CONNECT_RESPONDER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IOTCR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IOTCR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/iotcr_pkg.sv -----
// Types, constants and small decode tables for the ISO-on-TCP responder.
// No dependencies; used by the top level.
package iotcr_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  localparam int LEN_MIN_HDR   = 4;
  localparam int LEN_MIN_KIND  = 6;
  localparam int LEN_MIN_CR    = 11;
  localparam int LEN_MIN_SETUP = 25;
  localparam int ACK_LEN       = 27;
  localparam int ACK_HEAD_LEN  = 19;
  localparam int ACK_SRC_SHIFT = 2;

  localparam logic [3:0] COTP_CR = 4'hE;
  localparam logic [3:0] COTP_DT = 4'hF;
  localparam logic [7:0] COTP_CC = 8'hD0;

  localparam int POS_TYPE    = 5;
  localparam int POS_DREF_HI = 6;
  localparam int POS_DREF_LO = 7;
  localparam int POS_SREF_HI = 8;
  localparam int POS_SREF_LO = 9;
  localparam int POS_PDU_HI  = 11;
  localparam int POS_PDU_LO  = 12;

  localparam logic [2:0] CHK_VER    = 3'd0;
  localparam logic [2:0] CHK_RSVD   = 3'd1;
  localparam logic [2:0] CHK_LEN_HI = 3'd2;
  localparam logic [2:0] CHK_LEN_LO = 3'd3;
  localparam logic [2:0] CHK_KIND   = 3'd4;
  localparam logic [2:0] CHK_PROTO  = 3'd5;
  localparam logic [2:0] CHK_ROSCTR = 3'd6;
  localparam logic [2:0] CHK_FUNC   = 3'd7;

  localparam logic MODE_CC  = 1'b0;
  localparam logic MODE_ACK = 1'b1;

  function automatic logic [4:0] chk_addr(input logic [2:0] step);
    logic [4:0] a;
    unique case (step)
      CHK_VER:    a = 5'd0;
      CHK_RSVD:   a = 5'd1;
      CHK_LEN_HI: a = 5'd2;
      CHK_LEN_LO: a = 5'd3;
      CHK_KIND:   a = 5'd5;
      CHK_PROTO:  a = 5'd7;
      CHK_ROSCTR: a = 5'd8;
      CHK_FUNC:   a = 5'd17;
      default:    a = 5'd0;
    endcase
    return a;
  endfunction

  function automatic logic [7:0] chk_expect(input logic [2:0] step);
    logic [7:0] e;
    unique case (step)
      CHK_VER:    e = 8'h03;
      CHK_PROTO:  e = 8'h32;
      CHK_ROSCTR: e = 8'h01;
      CHK_FUNC:   e = 8'hF0;
      default:    e = 8'h00;
    endcase
    return e;
  endfunction

  function automatic logic [7:0] ack_head(input logic [4:0] idx);
    logic [7:0] b;
    unique case (idx)
      5'd0:    b = 8'h03;
      5'd3:    b = 8'h1B;
      5'd4:    b = 8'h02;
      5'd5:    b = 8'hF0;
      5'd6:    b = 8'h80;
      5'd7:    b = 8'h32;
      5'd8:    b = 8'h03;
      5'd14:   b = 8'h08;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/core/iotcr_store.sv -----
// Packet store of the ISO-on-TCP responder: one write port, one registered read port.
// No dependencies; instantiated by the top level.
module iotcr_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/iso_on_tcp_connect_responder.sv -----
// Top level of the ISO-on-TCP connection responder.
// Depends on iotcr_pkg, iotcr_store and iso_on_tcp_connect_responder_assert.svh.
//
// Request bytes are taken one per cycle while busy is low. After the final byte
// of a packet that fits the store and holds at least four bytes, the block goes
// busy and reads header bytes through the single read port of the packet store
// for its checks (at most eight reads). If all pass, it sends the response,
// each byte read from the store and then registered onto the output. A
// connection confirm is as long as the request, a setup acknowledgment 27 bytes.
// Each response byte is shown for exactly one cycle with out_valid high; the
// receiver must take every transfer as it comes.
module iso_on_tcp_connect_responder
  import iotcr_pkg::*;
#(
  parameter int MAX_PACKET = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_data,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output logic        out_valid,
  output out_item_t   out_data
);

  `include "iso_on_tcp_connect_responder_assert.svh"

  localparam int AW = $clog2(MAX_PACKET);
  localparam int CW = $clog2(MAX_PACKET + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_ERD  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [2:0]    step_r, step_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          too_long_r, too_long_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] end_r, end_nxt;
  logic          mode_r, mode_nxt;
  logic [15:0]   local_ref_r;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r, out_data_nxt;

  logic          accept;
  logic          full;
  logic          wr_en;
  logic [CW-1:0] new_count;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic [7:0]    cmp_exp;
  logic          cmp_eq;
  logic          emit_last;
  logic [CW-1:0] src_idx;
  logic [7:0]    emit_byte;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign full      = (count_r == CW'(MAX_PACKET));
  assign wr_en     = accept && !full;
  assign new_count = full ? count_r : CW'(count_r + 1'b1);

  always_comb begin
    src_idx = idx_r;
    if (mode_r == MODE_CC) begin
      if (idx_r == CW'(POS_DREF_HI)) begin
        src_idx = CW'(POS_SREF_HI);
      end else if (idx_r == CW'(POS_DREF_LO)) begin
        src_idx = CW'(POS_SREF_LO);
      end
    end else if (idx_r >= CW'(ACK_HEAD_LEN)) begin
      src_idx = CW'(idx_r - CW'(ACK_SRC_SHIFT));
    end
  end

  assign rd_addr = (state_r == S_ERD) ? AW'(src_idx) : AW'(chk_addr(step_r));

  iotcr_store #(
    .DEPTH (MAX_PACKET),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(count_r)),
    .wr_data (in_data.in_byte),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign cmp_exp   = (step_r == CHK_LEN_LO) ? 8'(len_r) : chk_expect(step_r);
  assign cmp_eq    = (rd_data == cmp_exp);
  assign emit_last = (CW'(idx_r + 1'b1) == end_r);

  always_comb begin
    emit_byte = rd_data;
    if (mode_r == MODE_CC) begin
      if (idx_r == CW'(POS_TYPE)) begin
        emit_byte = COTP_CC;
      end else if (idx_r == CW'(POS_SREF_HI)) begin
        emit_byte = local_ref_r[15:8];
      end else if (idx_r == CW'(POS_SREF_LO)) begin
        emit_byte = local_ref_r[7:0];
      end
    end else if (idx_r < CW'(ACK_HEAD_LEN) && idx_r != CW'(POS_PDU_HI) &&
                 idx_r != CW'(POS_PDU_LO)) begin
      emit_byte = ack_head(5'(idx_r));
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    count_nxt     = count_r;
    too_long_nxt  = too_long_r;
    len_nxt       = len_r;
    idx_nxt       = idx_r;
    end_nxt       = end_r;
    mode_nxt      = mode_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.in_last) begin
            count_nxt    = '0;
            too_long_nxt = 1'b0;
            len_nxt      = new_count;
            step_nxt     = CHK_VER;
            if (!(too_long_r || full) && new_count >= CW'(LEN_MIN_HDR)) begin
              state_nxt = S_RD;
            end
          end else begin
            count_nxt    = new_count;
            too_long_nxt = too_long_r || full;
          end
        end
      end
      S_RD: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        state_nxt = S_IDLE;
        idx_nxt   = '0;
        if (step_r == CHK_KIND) begin
          if (rd_data[7:4] == COTP_CR && len_r >= CW'(LEN_MIN_CR)) begin
            mode_nxt  = MODE_CC;
            end_nxt   = len_r;
            state_nxt = S_ERD;
          end else if (rd_data[7:4] == COTP_DT && len_r >= CW'(LEN_MIN_SETUP)) begin
            step_nxt  = CHK_PROTO;
            state_nxt = S_RD;
          end
        end else if (cmp_eq) begin
          if (step_r == CHK_FUNC) begin
            mode_nxt  = MODE_ACK;
            end_nxt   = CW'(ACK_LEN);
            state_nxt = S_ERD;
          end else if (step_r != CHK_LEN_LO || len_r >= CW'(LEN_MIN_KIND)) begin
            step_nxt  = step_r + 3'd1;
            state_nxt = S_RD;
          end
        end
      end
      S_ERD: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        out_valid_nxt         = 1'b1;
        out_data_nxt.out_byte = emit_byte;
        out_data_nxt.out_last = emit_last;
        idx_nxt               = CW'(idx_r + 1'b1);
        state_nxt             = emit_last ? S_IDLE : S_ERD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= CHK_VER;
      count_r     <= '0;
      too_long_r  <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      local_ref_r <= 16'h0001;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      count_r     <= count_nxt;
      too_long_r  <= too_long_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        local_ref_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    len_r      <= len_nxt;
    end_r      <= end_nxt;
    mode_r     <= mode_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `IOTCR_ASSERT_NOW(a_strobe_from_emit, clk, rst_n, out_valid_r,
                    $past(state_r == S_EMIT), "Output strobe without an emit cycle.")
  `IOTCR_ASSERT_NEXT(a_last_ends_response, clk, rst_n, state_r == S_EMIT && emit_last,
                     state_r == S_IDLE && out_data_r.out_last, "Response did not end on its final byte.")
  `IOTCR_ASSERT_NOW(a_index_in_range, clk, rst_n, state_r == S_ERD || state_r == S_EMIT,
                    idx_r < end_r, "Response index ran past the response length.")
  `IOTCR_ASSERT_NEXT(a_overlong_dropped, clk, rst_n,
                     accept && in_data.in_last && (too_long_r || full),
                     state_r == S_IDLE && count_r == '0, "Overlong packet was not dropped.")

endmodule
